// ===== rtl/wocs_pkg.sv =====
package wocs_pkg;

    // Record layout and fixed bit patterns.
    localparam logic [31:0] REC_MAGIC = 32'hCA11B0A0;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ERASED    = 32'hFFFFFFFF;
    localparam logic [31:0] ONE_BITS  = 32'h3F800000;
    localparam logic [31:0] ZERO_BITS = 32'h00000000;
    localparam int unsigned RecWords  = 5;

    // Action codes of a request.
    localparam logic [2:0] ACT_QUERY  = 3'd0;
    localparam logic [2:0] ACT_SET_G  = 3'd1;
    localparam logic [2:0] ACT_SET_O  = 3'd2;
    localparam logic [2:0] ACT_COMMIT = 3'd3;
    localparam logic [2:0] ACT_ERASE  = 3'd4;
    localparam logic [2:0] ACT_RELOAD = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       set_ok;
        logic       set_gain;
        logic       set_offset;
        logic       erase_all;
        logic       prep_commit;
        logic       crc_clear;
        logic       crc_step;
        logic       mem_write;
        logic       rd_issue;
        logic       commit_lock;
        logic       scan_clear;
        logic       scan_next;
        logic       apply_reload;
        logic       resp_load;
        logic [2:0] word_idx;
        logic [6:0] bit_idx;
    } wocs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] action;
        logic       inr;
        logic       slot_locked;
        logic       slot_written;
        logic       scan_written;
        logic       scan_last;
    } wocs_stat_t;

endpackage

// ===== rtl/wocs_ctrl.sv =====
module wocs_ctrl
    import wocs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  wocs_stat_t stat,
    output wocs_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_CWR   = 3'd3;
    localparam logic [2:0] ST_RSCAN = 3'd4;
    localparam logic [2:0] ST_RRD   = 3'd5;
    localparam logic [2:0] ST_RAPP  = 3'd6;
    localparam logic [2:0] ST_RESP  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] word_reg, word_next;
    logic [6:0] bit_reg, bit_next;
    logic       commit_reg, commit_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer for one request at a time.
    always_comb begin
        state_next   = state_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        commit_next  = commit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.word_idx = word_reg;
        cmd.bit_idx  = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_RESP;
                unique case (stat.action)
                    ACT_QUERY: begin
                        cmd.set_ok = stat.inr;
                    end
                    ACT_SET_G: begin
                        if (stat.inr && !stat.slot_locked) begin
                            cmd.set_gain = 1'b1;
                            cmd.set_ok   = 1'b1;
                        end
                    end
                    ACT_SET_O: begin
                        if (stat.inr && !stat.slot_locked) begin
                            cmd.set_offset = 1'b1;
                            cmd.set_ok     = 1'b1;
                        end
                    end
                    ACT_COMMIT: begin
                        if (stat.inr && !stat.slot_locked && !stat.slot_written) begin
                            cmd.prep_commit = 1'b1;
                            cmd.crc_clear   = 1'b1;
                            commit_next     = 1'b1;
                            bit_next        = '0;
                            state_next      = ST_CRC;
                        end
                    end
                    ACT_ERASE: begin
                        cmd.erase_all = 1'b1;
                        cmd.set_ok    = 1'b1;
                    end
                    ACT_RELOAD: begin
                        cmd.scan_clear = 1'b1;
                        commit_next    = 1'b0;
                        state_next     = ST_RSCAN;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_CRC: begin
                cmd.crc_step = 1'b1;
                bit_next     = bit_reg + 7'd1;
                if (bit_reg == 7'd127) begin
                    word_next  = '0;
                    state_next = commit_reg ? ST_CWR : ST_RAPP;
                end
            end
            ST_CWR: begin
                cmd.mem_write = 1'b1;
                word_next     = word_reg + 3'd1;
                if (word_reg == 3'(RecWords - 1)) begin
                    cmd.commit_lock = 1'b1;
                    cmd.set_ok      = 1'b1;
                    state_next      = ST_RESP;
                end
            end
            ST_RSCAN: begin
                if (stat.scan_written) begin
                    word_next  = '0;
                    state_next = ST_RRD;
                end else begin
                    // An erased record always falls back to defaults.
                    cmd.apply_reload = 1'b1;
                    if (stat.scan_last) begin
                        cmd.set_ok = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        cmd.scan_next = 1'b1;
                    end
                end
            end
            ST_RRD: begin
                // Reads go out one a cycle and land via rd_data_reg.
                cmd.rd_issue = (word_reg < 3'(RecWords));
                word_next    = word_reg + 3'd1;
                if (word_reg == 3'(RecWords)) begin
                    cmd.crc_clear = 1'b1;
                    bit_next      = '0;
                    state_next    = ST_CRC;
                end
            end
            ST_RAPP: begin
                cmd.apply_reload = 1'b1;
                if (stat.scan_last) begin
                    cmd.set_ok = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_RSCAN;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.resp_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            word_reg    <= '0;
            bit_reg     <= '0;
            commit_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            bit_reg     <= bit_next;
            commit_reg  <= commit_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/wocs_dp.sv =====
module wocs_dp
    import wocs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int GAIN_CLASSES = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  wocs_cmd_t   cmd,
    output wocs_stat_t  stat,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_channel,
    input  logic [1:0]  s_gain_class,
    input  logic [31:0] s_value,
    output logic        m_ok,
    output logic [31:0] m_gain_bits,
    output logic [31:0] m_offset_bits,
    output logic        m_locked,
    output logic [31:0] m_lock_mask
);

    localparam int SLOTS     = CHANNELS * GAIN_CLASSES;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int GC_W      = (GAIN_CLASSES > 1) ? $clog2(GAIN_CLASSES) : 1;
    localparam int MEM_DEPTH = SLOTS * RecWords;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Captured request.
    logic [2:0]  act_reg;
    logic [3:0]  ch_reg;
    logic [1:0]  gc_reg;
    logic [31:0] val_reg;
    logic        ok_reg;

    // Live slot state.
    logic [31:0]      gain_reg [SLOTS];
    logic [31:0]      offset_reg [SLOTS];
    logic [SLOTS-1:0] lock_reg;
    logic [SLOTS-1:0] written_reg;

    // Record store and its read path.
    logic [31:0]       rec_mem [MEM_DEPTH];
    logic [31:0]       rd_data_reg;
    logic              rd_pend_reg;
    logic [2:0]        rd_idx_reg;
    logic [31:0]       rec_reg [RecWords];
    logic [31:0]       crc_reg;

    // Reload scan position.
    logic [CH_W-1:0] kc_reg;
    logic [GC_W-1:0] kg_reg;

    logic              inr;
    logic [SLOT_W-1:0] s_idx;
    logic [SLOT_W-1:0] k_idx;
    logic [SLOT_W-1:0] op_idx;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       wr_data;
    logic              crc_bit;
    logic              crc_fb;
    logic              rec_match;

    // Slot addressed by the request, and slot under the reload scan.
    assign inr   = (32'(ch_reg) < 32'(CHANNELS)) && (32'(gc_reg) < 32'(GAIN_CLASSES));
    assign s_idx = inr ? SLOT_W'(32'(ch_reg) * 32'(GAIN_CLASSES) + 32'(gc_reg)) : '0;
    assign k_idx = SLOT_W'(32'(kc_reg) * 32'(GAIN_CLASSES) + 32'(kg_reg));

    // Commit writes the request's slot; reload reads the scanned one.
    assign op_idx   = cmd.rd_issue ? k_idx : s_idx;
    assign mem_addr = ADDR_W'(32'(op_idx) * RecWords + 32'(cmd.word_idx));
    assign wr_data  = (cmd.word_idx == 3'(RecWords - 1)) ? ~crc_reg
                                                           : rec_reg[cmd.word_idx];

    // Bit-serial CRC over four words, low byte first, low bit first.
    assign crc_bit = rec_reg[{1'b0, cmd.bit_idx[6:5]}][cmd.bit_idx[4:0]];
    assign crc_fb  = crc_reg[0] ^ crc_bit;

    // A record is good when it is marked written and magic, ids and checksum all agree.
    assign rec_match = written_reg[k_idx]
                    && (rec_reg[0] == REC_MAGIC)
                    && (rec_reg[1][7:0] == 8'(kc_reg))
                    && (rec_reg[1][15:8] == 8'(kg_reg))
                    && (rec_reg[4] == ~crc_reg);

    assign stat.action       = act_reg;
    assign stat.inr          = inr;
    assign stat.slot_locked  = lock_reg[s_idx];
    assign stat.slot_written = written_reg[s_idx];
    assign stat.scan_written = written_reg[k_idx];
    assign stat.scan_last    = (kc_reg == CH_W'(CHANNELS - 1))
                            && (kg_reg == GC_W'(GAIN_CLASSES - 1));

    // Request capture and result flag.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            act_reg <= s_action;
            ch_reg  <= s_channel;
            gc_reg  <= s_gain_class;
            val_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else if (cmd.load_req) begin
            ok_reg <= 1'b0;
        end else if (cmd.set_ok) begin
            ok_reg <= 1'b1;
        end
    end

    // Live gain, offset, lock and record-written flags.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.erase_all) begin
            for (int i = 0; i < SLOTS; i++) begin
                gain_reg[i]   <= ONE_BITS;
                offset_reg[i] <= ZERO_BITS;
            end
            lock_reg    <= '0;
            written_reg <= '0;
        end else begin
            if (cmd.set_gain) begin
                gain_reg[s_idx] <= val_reg;
            end
            if (cmd.set_offset) begin
                offset_reg[s_idx] <= val_reg;
            end
            if (cmd.commit_lock) begin
                lock_reg[s_idx]    <= 1'b1;
                written_reg[s_idx] <= 1'b1;
            end
            if (cmd.apply_reload) begin
                if (rec_match) begin
                    gain_reg[k_idx]   <= rec_reg[2];
                    offset_reg[k_idx] <= rec_reg[3];
                    lock_reg[k_idx]   <= 1'b1;
                end else begin
                    gain_reg[k_idx]   <= ONE_BITS;
                    offset_reg[k_idx] <= ZERO_BITS;
                    lock_reg[k_idx]   <= 1'b0;
                end
            end
        end
    end

    // Record store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            rec_mem[mem_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= rec_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_idx_reg <= cmd.word_idx;
        end
    end

    // Record words under check, either staged for commit or read back.
    always_ff @(posedge aclk) begin
        if (cmd.prep_commit) begin
            rec_reg[0] <= REC_MAGIC;
            rec_reg[1] <= {16'h0000, 6'b000000, gc_reg, 4'b0000, ch_reg};
            rec_reg[2] <= gain_reg[s_idx];
            rec_reg[3] <= offset_reg[s_idx];
        end else if (rd_pend_reg) begin
            rec_reg[rd_idx_reg] <= rd_data_reg;
        end
    end

    // CRC register, one message bit per step.
    always_ff @(posedge aclk) begin
        if (cmd.crc_clear) begin
            crc_reg <= ERASED;
        end else if (cmd.crc_step) begin
            crc_reg <= (crc_reg >> 1) ^ (crc_fb ? CRC_POLY : 32'h0);
        end
    end

    // Reload scan counters, channel major.
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            kc_reg <= '0;
            kg_reg <= '0;
        end else if (cmd.scan_next) begin
            if (kg_reg == GC_W'(GAIN_CLASSES - 1)) begin
                kg_reg <= '0;
                kc_reg <= kc_reg + CH_W'(1);
            end else begin
                kg_reg <= kg_reg + GC_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            m_ok          <= ok_reg;
            m_gain_bits   <= inr ? gain_reg[s_idx] : ONE_BITS;
            m_offset_bits <= inr ? offset_reg[s_idx] : ZERO_BITS;
            m_locked      <= inr && lock_reg[s_idx];
            m_lock_mask   <= 32'(lock_reg);
        end
    end

endmodule

// ===== rtl/write_once_calibration_store.sv =====
// Calibration store with write-once records: one request in, one result out.
// A query, set, erase or unused code goes from acceptance through a dispatch
// step and a result step. A commit goes through dispatch, the bit-serial
// CRC-32, which walks the 128 record bits one bit per cycle, five single-port
// record writes and the result step. A reload goes through dispatch, a share
// for each of the CHANNELS * GAIN_CLASSES slots and the result step. An erased
// slot costs only its scan step; a written record costs a scan step, the reads
// of its five record words, the CRC over its 128 bits and an apply step.
// No clearing pass follows reset: a written flag per record makes an unwritten
// record read as erased. A new request is taken while the previous result
// still waits on the output. The result step stalls until that earlier
// result is accepted. The next request can be accepted in the same cycle
// that a result is raised.
module write_once_calibration_store
    import wocs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int GAIN_CLASSES = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_channel,
    input  logic [1:0]  s_gain_class,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_gain_bits,
    output logic [31:0] m_offset_bits,
    output logic        m_locked,
    output logic [31:0] m_lock_mask
);

    wocs_cmd_t  cmd;
    wocs_stat_t stat;

    // Sequencer.
    wocs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot state, record store and CRC.
    wocs_dp #(
        .CHANNELS     (CHANNELS),
        .GAIN_CLASSES (GAIN_CLASSES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_action      (s_action),
        .s_channel     (s_channel),
        .s_gain_class  (s_gain_class),
        .s_value       (s_value),
        .m_ok          (m_ok),
        .m_gain_bits   (m_gain_bits),
        .m_offset_bits (m_offset_bits),
        .m_locked      (m_locked),
        .m_lock_mask   (m_lock_mask)
    );

endmodule

// ===== sim/calibration_checker.sv =====
module calibration_checker
    import wocs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int GAIN_CLASSES = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_channel,
    input  logic [1:0]  s_gain_class,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [31:0] m_gain_bits,
    input  logic [31:0] m_offset_bits,
    input  logic        m_locked,
    input  logic [31:0] m_lock_mask,
    output int          mismatch_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Slots = CHANNELS * GAIN_CLASSES;

    typedef struct packed {
        logic        ok;
        logic [31:0] gain_bits;
        logic [31:0] offset_bits;
        logic        locked;
        logic [31:0] lock_mask;
    } outcome_t;

    logic [31:0] trim_gain   [Slots];
    logic [31:0] trim_offset [Slots];
    logic        trim_locked [Slots];
    logic [31:0] flash_words [Slots*RecWords];
    outcome_t    expected_outcomes [$];

    // Reflected CRC-32 over four words sent as 16 little-endian bytes.
    function automatic logic [31:0] record_crc(logic [31:0] w0, logic [31:0] w1,
                                               logic [31:0] w2, logic [31:0] w3);
        logic [31:0] crc;
        logic [127:0] bits;
        crc  = 32'hFFFFFFFF;
        bits = {w3, w2, w1, w0};
        for (int i = 0; i < 128; i++) begin
            crc = ((crc[0] ^ bits[i]) != 1'b0) ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return ~crc;
    endfunction

    function automatic void clear_trim(int s);
        trim_gain[s]   = ONE_BITS;
        trim_offset[s] = ZERO_BITS;
        trim_locked[s] = 1'b0;
    endfunction

    // Applies one request to the shadow state and returns the expected result.
    function automatic outcome_t apply_request(logic [2:0] act, logic [3:0] ch,
                                               logic [1:0] gc, logic [31:0] val);
        outcome_t o;
        bit inr;
        bit erased;
        int s;
        int b;
        inr = (ch < CHANNELS) && (gc < GAIN_CLASSES);
        s = inr ? ch * GAIN_CLASSES + gc : 0;
        o = '0;
        case (act)
            ACT_QUERY: o.ok = inr;
            ACT_SET_G, ACT_SET_O: begin
                if (inr && !trim_locked[s]) begin
                    if (act == ACT_SET_G) trim_gain[s] = val;
                    else trim_offset[s] = val;
                    o.ok = 1'b1;
                end
            end
            ACT_COMMIT: begin
                if (inr && !trim_locked[s]) begin
                    b = s * RecWords;
                    erased = 1;
                    for (int i = 0; i < RecWords; i++)
                        if (flash_words[b+i] != ERASED) erased = 0;
                    if (erased) begin
                        flash_words[b]   = REC_MAGIC;
                        flash_words[b+1] = {22'd0, gc, 4'd0, ch};
                        flash_words[b+2] = trim_gain[s];
                        flash_words[b+3] = trim_offset[s];
                        flash_words[b+4] = record_crc(flash_words[b], flash_words[b+1],
                                                      flash_words[b+2], flash_words[b+3]);
                        trim_locked[s] = 1'b1;
                        o.ok = 1'b1;
                    end
                end
            end
            ACT_ERASE: begin
                foreach (flash_words[i]) flash_words[i] = ERASED;
                for (int i = 0; i < Slots; i++) clear_trim(i);
                o.ok = 1'b1;
            end
            ACT_RELOAD: begin
                for (int k = 0; k < Slots; k++) begin
                    b = k * RecWords;
                    if (flash_words[b] == REC_MAGIC &&
                        flash_words[b+1][7:0] == k / GAIN_CLASSES &&
                        flash_words[b+1][15:8] == k % GAIN_CLASSES &&
                        flash_words[b+4] == record_crc(flash_words[b], flash_words[b+1],
                                                       flash_words[b+2], flash_words[b+3])) begin
                        trim_gain[k]   = flash_words[b+2];
                        trim_offset[k] = flash_words[b+3];
                        trim_locked[k] = 1'b1;
                    end else begin
                        clear_trim(k);
                    end
                end
                o.ok = 1'b1;
            end
            default: o.ok = 1'b0;
        endcase
        o.gain_bits   = inr ? trim_gain[s] : ONE_BITS;
        o.offset_bits = inr ? trim_offset[s] : ZERO_BITS;
        o.locked      = inr && trim_locked[s];
        for (int i = 0; i < Slots && i < 32; i++)
            if (trim_locked[i]) o.lock_mask[i] = 1'b1;
        return o;
    endfunction

    assign pending_count = expected_outcomes.size();

    initial begin
        for (int i = 0; i < Slots; i++) clear_trim(i);
        foreach (flash_words[i]) flash_words[i] = ERASED;
        mismatch_count = 0;
        result_count = 0;
    end

    // Predict on every accepted request and compare every accepted result.
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                seen = {m_ok, m_gain_bits, m_offset_bits, m_locked, m_lock_mask};
                if (expected_outcomes.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("MISMATCH: result with no request pending: %h", seen);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (want != seen) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display({"MISMATCH: ok %b/%b gain %h/%h offset %h/%h ",
                                      "locked %b/%b mask %h/%h (expected/actual)"},
                                     want.ok, seen.ok, want.gain_bits, seen.gain_bits,
                                     want.offset_bits, seen.offset_bits,
                                     want.locked, seen.locked,
                                     want.lock_mask, seen.lock_mask);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_outcomes.push_back(apply_request(s_action, s_channel,
                                                          s_gain_class, s_value));
        end
    end
endmodule

// ===== sim/write_once_calibration_store_tb.sv =====
module write_once_calibration_store_tb;
    import wocs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic [3:0]  s_channel;
    logic [1:0]  s_gain_class;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic        m_ok;
    logic [31:0] m_gain_bits;
    logic [31:0] m_offset_bits;
    logic        m_locked;
    logic [31:0] m_lock_mask;
    int          mismatch_count;
    int          pending_count;
    int          result_count;
    bit          calm_phase;
    bit          hold_off;

    write_once_calibration_store DUT (.*);

    calibration_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #80ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Sends one request and waits until it is accepted. Valid stays high
    // into the next request unless an idle burst comes first.
    task automatic send_request(logic [2:0] act, logic [3:0] ch,
                                logic [1:0] gc, logic [31:0] val);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_channel    <= ch;
        s_gain_class <= gc;
        s_value      <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random action mix: mostly sets and queries, with occasional commits,
    // reloads, unused codes and rare erases so that records fill and get cleared again.
    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return ACT_QUERY;
        if (r < 50) return ACT_SET_G;
        if (r < 72) return ACT_SET_O;
        if (r < 84) return ACT_COMMIT;
        if (r < 91) return ACT_RELOAD;
        if (r < 94) return ACT_ERASE;
        return 3'($urandom_range(6, 7));
    endfunction

    // Receiver side: random stall bursts, one long hold-off, none at the end.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    initial begin
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_QUERY;
        s_channel = '0;
        s_gain_class = '0;
        s_value = '0;
        calm_phase = 1'b0;
        hold_off = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, each action, locked and out-of-range slots,
        // commit over a written record, reload of valid and cleared records.
        send_request(ACT_QUERY, 4'd0, 2'd0, 32'h0);
        send_request(ACT_QUERY, 4'd15, 2'd3, 32'hFFFFFFFF);
        send_request(ACT_SET_G, 4'd0, 2'd0, 32'hFFFFFFFF);
        send_request(ACT_SET_O, 4'd0, 2'd0, 32'h80000001);
        send_request(ACT_SET_G, 4'd8, 2'd0, 32'h12345678);
        send_request(ACT_SET_O, 4'd3, 2'd1, 32'h12345678);
        send_request(ACT_COMMIT, 4'd0, 2'd0, 32'h0);
        send_request(ACT_SET_G, 4'd0, 2'd0, 32'h0);
        send_request(ACT_COMMIT, 4'd0, 2'd0, 32'h0);
        send_request(ACT_COMMIT, 4'd9, 2'd0, 32'h0);
        send_request(ACT_SET_G, 4'd7, 2'd0, 32'h7F7FFFFF);
        send_request(ACT_COMMIT, 4'd7, 2'd0, 32'h0);
        send_request(ACT_RELOAD, 4'd15, 2'd3, 32'h0);
        send_request(ACT_QUERY, 4'd7, 2'd0, 32'h0);
        send_request(3'd6, 4'd7, 2'd0, 32'h0);
        send_request(3'd7, 4'd12, 2'd2, 32'h0);
        send_request(ACT_ERASE, 4'd4, 2'd0, 32'h0);
        send_request(ACT_RELOAD, 4'd0, 2'd0, 32'h0);
        send_request(ACT_QUERY, 4'd0, 2'd0, 32'h0);

        // Random traffic; a long receiver hold-off early on.
        for (int n = 0; n < 1430; n++) begin
            if (n == 40) hold_off = 1'b1;
            if (n == 1250) calm_phase = 1'b1;
            send_request(pick_action(),
                         ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                     : 4'($urandom_range(0, 7)),
                         ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0,
                         $urandom());
        end
        s_valid <= 1'b0;

        // Drain with a bound, then let the block settle.
        waited = 0;
        while (pending_count != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        $display("Ran %0d results over all six actions plus unused codes,", result_count);
        $display("with out-of-range slots, locks, commits, erases and reloads.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/wocs_pkg.sv
rtl/wocs_ctrl.sv
rtl/wocs_dp.sv
rtl/write_once_calibration_store.sv
sim/calibration_checker.sv
sim/write_once_calibration_store_tb.sv
